// File: rtl/hmcp_pkg.sv
// Shared types, constants and helpers for the hex monitor command parser.
package hmcp_pkg;

   localparam int unsigned CHECKSUM_BYTES = 2;
   localparam logic [7:0]  ERROR_LIMIT    = 8'd128;

   localparam logic [2:0] KIND_WRITE      = 3'd0;
   localparam logic [2:0] KIND_DUMP_LINE  = 3'd1;
   localparam logic [2:0] KIND_DUMP_RANGE = 3'd2;
   localparam logic [2:0] KIND_EXECUTE    = 3'd3;
   localparam logic [2:0] KIND_ERROR      = 3'd4;

   localparam logic CAUSE_BAD_COMMAND = 1'b0;
   localparam logic CAUSE_CHECKSUM    = 1'b1;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DASH    = 8'h2D;
   localparam logic [7:0] CHAR_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_UPPER_G = 8'h47;
   localparam logic [7:0] CHAR_LOWER_G = 8'h67;
   localparam logic [7:0] CHAR_UPPER_X = 8'h58;
   localparam logic [7:0] CHAR_LOWER_X = 8'h78;

   localparam logic [2:0] DIGITS_MAX = 3'd4;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_ADDR,
      MODE_RANGE,
      MODE_WRITE,
      MODE_CHECK,
      MODE_GO
   } mode_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      return v[3:0];
   endfunction

endpackage

// File: rtl/hex_monitor_command_parser.sv
// Hex monitor command parser: one character in, at most one command out.
//
// Takes one ASCII character per transaction and turns the monitor command
// language into memory write, dump line, dump range, execute and error
// commands. A character is held in an input register and then decoded into
// the result register, so one character is taken every cycle while the
// result side is not stalled. While a
// finished result waits on rsp_ready the decoder holds, the input register
// takes at most one more character, and req_ready then stays low until the
// result is taken. Checksum errors count up to 128 and then report the limit
// as reached.
module hex_monitor_command_parser
   import hmcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_address,
   output logic [15:0] rsp_end_address,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_error_cause,
   output logic        rsp_error_limit_reached
);

   logic        in_valid_ff;
   logic [7:0]  char_ff;
   mode_type    mode_ff, mode_in;
   logic [15:0] cur_ff, cur_in;
   logic [15:0] wp_ff, wp_in;
   logic [15:0] acc_ff, acc_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [7:0]  cks0_ff, cks0_in;
   logic [7:0]  cks1_ff, cks1_in;
   logic        pos_ff, pos_in;
   logic [7:0]  mm_ff, mm_in;

   logic        rsp_valid_ff;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] end_ff, end_in;
   logic [7:0]  data_ff, data_in;
   logic        cause_ff, cause_in;
   logic        lim_ff, lim_in;
   logic        emit;

   logic        advance;
   logic        c_hex;
   logic [3:0]  c_val;
   logic [15:0] acc_push;
   logic [2:0]  cnt_push;
   logic        idle_sel;
   logic [15:0] cur_eff;
   logic [15:0] line_end;
   logic [7:0]  wr_byte;
   logic        wr_now;
   logic [7:0]  rd0, rd1;
   logic        sum_ok;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign c_hex    = is_hex(char_ff);
   assign c_val    = hex_value(char_ff);
   assign acc_push = {acc_ff[11:0], c_val};
   assign cnt_push = cnt_ff + 3'd1;
   assign cur_eff  = (mode_ff == MODE_ADDR) ? acc_ff : cur_ff;
   assign line_end = cur_eff | 16'h0007;

   assign idle_sel = (mode_ff == MODE_IDLE) || (mode_ff == MODE_ADDR && !c_hex) ||
                     (mode_ff != MODE_ADDR && mode_ff != MODE_RANGE &&
                      mode_ff != MODE_WRITE && mode_ff != MODE_CHECK &&
                      mode_ff != MODE_GO);

   assign wr_now  = (mode_ff == MODE_WRITE) && (c_hex ? (cnt_ff != 3'd0) : (cnt_ff != 3'd0));
   assign wr_byte = c_hex ? {acc_ff[3:0], c_val} : acc_ff[7:0];

   always_comb begin
      rd0 = acc_ff[7:0];
      rd1 = 8'h00;
      case (cnt_ff)
         3'd3: begin
            rd0 = acc_ff[11:4];
            rd1 = {4'h0, acc_ff[3:0]};
         end
         3'd4: begin
            rd0 = acc_ff[15:8];
            rd1 = acc_ff[7:0];
         end
         default: begin
            rd0 = acc_ff[7:0];
            rd1 = 8'h00;
         end
      endcase
   end

   assign sum_ok = (rd0 == cks0_ff) && ((CHECKSUM_BYTES < 2) || (rd1 == cks1_ff));

   // next mode
   always_comb begin
      mode_in = mode_ff;
      if (idle_sel) begin
         mode_in = MODE_IDLE;
         if (c_hex) begin
            mode_in = MODE_ADDR;
         end else if (char_ff == CHAR_DOT) begin
            mode_in = MODE_RANGE;
         end else if (char_ff == CHAR_DASH || char_ff == CHAR_COLON) begin
            mode_in = MODE_WRITE;
         end else if (char_ff == CHAR_UPPER_G || char_ff == CHAR_LOWER_G) begin
            mode_in = MODE_GO;
         end
      end else begin
         unique case (mode_ff)
            MODE_ADDR: begin
               if (cnt_push >= DIGITS_MAX) mode_in = MODE_IDLE;
            end
            MODE_RANGE, MODE_CHECK: begin
               if (!(c_hex && cnt_ff < DIGITS_MAX)) mode_in = MODE_IDLE;
            end
            MODE_WRITE: begin
               if (!c_hex && char_ff != CHAR_SPACE) begin
                  mode_in = (char_ff == CHAR_UPPER_X || char_ff == CHAR_LOWER_X) ?
                            MODE_CHECK : MODE_IDLE;
               end
            end
            MODE_GO: begin
               if (char_ff == CHAR_NEWLINE) mode_in = MODE_IDLE;
            end
            default: mode_in = MODE_IDLE;
         endcase
      end
   end

   // datapath and result
   always_comb begin
      cur_in   = cur_ff;
      wp_in    = wp_ff;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      cks0_in  = cks0_ff;
      cks1_in  = cks1_ff;
      pos_in   = pos_ff;
      mm_in    = mm_ff;
      emit     = 1'b0;
      kind_in  = KIND_WRITE;
      addr_in  = 16'h0000;
      end_in   = 16'h0000;
      data_in  = 8'h00;
      cause_in = CAUSE_BAD_COMMAND;
      lim_in   = 1'b0;
      if (idle_sel) begin
         cur_in = cur_eff;
         if (c_hex) begin
            acc_in = {12'h000, c_val};
            cnt_in = 3'd1;
         end else if (char_ff == CHAR_NEWLINE) begin
            emit    = 1'b1;
            kind_in = KIND_DUMP_LINE;
            addr_in = cur_eff;
            end_in  = line_end;
            cur_in  = line_end + 16'd1;
         end else if (char_ff == CHAR_DOT) begin
            acc_in = 16'h0000;
            cnt_in = 3'd0;
         end else if (char_ff == CHAR_DASH || char_ff == CHAR_COLON) begin
            wp_in   = cur_eff;
            cks0_in = 8'h00;
            cks1_in = 8'h00;
            pos_in  = 1'b0;
            acc_in  = 16'h0000;
            cnt_in  = 3'd0;
         end else if (char_ff == CHAR_UPPER_G || char_ff == CHAR_LOWER_G ||
                      char_ff == CHAR_SPACE) begin
            emit = 1'b0;
         end else begin
            emit     = 1'b1;
            kind_in  = KIND_ERROR;
            cause_in = CAUSE_BAD_COMMAND;
         end
      end else begin
         case (mode_ff)
            MODE_ADDR: begin
               acc_in = acc_push;
               cnt_in = cnt_push;
               if (cnt_push >= DIGITS_MAX) cur_in = acc_push;
            end
            MODE_RANGE: begin
               if (c_hex && cnt_ff < DIGITS_MAX) begin
                  acc_in = acc_push;
                  cnt_in = cnt_push;
               end else begin
                  emit    = 1'b1;
                  kind_in = KIND_DUMP_RANGE;
                  addr_in = cur_ff;
                  end_in  = acc_ff;
                  cur_in  = (acc_ff >= cur_ff || cur_ff == 16'hFFFF) ?
                            acc_ff + 16'd1 : cur_ff + 16'd1;
                  acc_in  = 16'h0000;
                  cnt_in  = 3'd0;
               end
            end
            MODE_WRITE: begin
               if (c_hex) begin
                  acc_in = acc_push;
                  cnt_in = cnt_push;
               end
               if (wr_now) begin
                  emit    = 1'b1;
                  kind_in = KIND_WRITE;
                  addr_in = wp_ff;
                  data_in = wr_byte;
                  if (pos_ff) begin
                     cks1_in = cks1_ff ^ wr_byte;
                  end else begin
                     cks0_in = cks0_ff ^ wr_byte;
                  end
                  pos_in = (CHECKSUM_BYTES > 1) ? ~pos_ff : 1'b0;
                  wp_in  = wp_ff + 16'd1;
                  acc_in = 16'h0000;
                  cnt_in = 3'd0;
               end
               if (!c_hex && char_ff != CHAR_SPACE) begin
                  if (char_ff == CHAR_UPPER_X || char_ff == CHAR_LOWER_X) begin
                     acc_in = 16'h0000;
                     cnt_in = 3'd0;
                  end else begin
                     cur_in = wp_in;
                  end
               end
            end
            MODE_CHECK: begin
               if (c_hex && cnt_ff < DIGITS_MAX) begin
                  acc_in = acc_push;
                  cnt_in = cnt_push;
               end else begin
                  acc_in = 16'h0000;
                  cnt_in = 3'd0;
                  if (sum_ok) begin
                     cur_in = wp_ff;
                  end else begin
                     emit     = 1'b1;
                     kind_in  = KIND_ERROR;
                     cause_in = CAUSE_CHECKSUM;
                     if (mm_ff >= ERROR_LIMIT) begin
                        lim_in = 1'b1;
                     end else begin
                        mm_in = mm_ff + 8'd1;
                     end
                  end
               end
            end
            MODE_GO: begin
               if (char_ff == CHAR_NEWLINE) begin
                  emit    = 1'b1;
                  kind_in = KIND_EXECUTE;
                  addr_in = cur_ff;
               end
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         char_ff <= req_char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         cur_ff  <= 16'h0000;
         wp_ff   <= 16'h0000;
         acc_ff  <= 16'h0000;
         cnt_ff  <= 3'd0;
         cks0_ff <= 8'h00;
         cks1_ff <= 8'h00;
         pos_ff  <= 1'b0;
         mm_ff   <= 8'h00;
      end else if (advance) begin
         mode_ff <= mode_in;
         cur_ff  <= cur_in;
         wp_ff   <= wp_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         cks0_ff <= cks0_in;
         cks1_ff <= cks1_in;
         pos_ff  <= pos_in;
         mm_ff   <= mm_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= emit;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         kind_ff  <= kind_in;
         addr_ff  <= addr_in;
         end_ff   <= end_in;
         data_ff  <= data_in;
         cause_ff <= cause_in;
         lim_ff   <= lim_in;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_kind                = kind_ff;
   assign rsp_address             = addr_ff;
   assign rsp_end_address         = end_ff;
   assign rsp_data_byte           = data_ff;
   assign rsp_error_cause         = cause_ff;
   assign rsp_error_limit_reached = lim_ff;

`ifndef SYNTHESIS
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DIGITS_MAX)
      else $error("digit count above four");

   a_mismatch_bound: assert property (@(posedge clock) disable iff (reset)
      mm_ff <= ERROR_LIMIT)
      else $error("mismatch count above limit");

   a_limit_is_checksum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_limit_reached |->
         rsp_kind == KIND_ERROR && rsp_error_cause == CAUSE_CHECKSUM)
      else $error("limit flag on a result that is not a checksum error");

   a_dump_line_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DUMP_LINE |->
         rsp_end_address == (rsp_address | 16'h0007))
      else $error("dump line end does not match start");
`endif

endmodule

// File: bench/testbench.sv
// Self-checking testbench for the hex monitor command parser.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hmcp_pkg::*;

   localparam int CLOCK_HALF   = 5;
   localparam int RESET_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_ITEMS = 800;
   localparam int FLOOD_LINES  = 135;
   localparam int BYTE_DIGITS  = 2;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] address;
      logic [15:0] end_address;
      logic [7:0]  data_byte;
      logic        error_cause;
      logic        error_limit_reached;
   } command_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_address;
   logic [15:0] rsp_end_address;
   logic [7:0]  rsp_data_byte;
   logic        rsp_error_cause;
   logic        rsp_error_limit_reached;

   hex_monitor_command_parser u_dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_char_in             (req_char_in),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_kind                (rsp_kind),
      .rsp_address             (rsp_address),
      .rsp_end_address         (rsp_end_address),
      .rsp_data_byte           (rsp_data_byte),
      .rsp_error_cause         (rsp_error_cause),
      .rsp_error_limit_reached (rsp_error_limit_reached)
   );

   always #(CLOCK_HALF) clock = ~clock;

   // parser state as predicted from the accepted characters
   mode_type    p_mode      = MODE_IDLE;
   logic [15:0] p_addr      = 16'h0000;
   logic [15:0] p_wptr      = 16'h0000;
   logic [15:0] p_acc       = 16'h0000;
   logic [2:0]  p_ndig      = 3'd0;
   logic [7:0]  p_sum [2]   = '{8'h00, 8'h00};
   logic        p_sum_pos   = 1'b0;
   logic [7:0]  p_err_count = 8'h00;

   command_type pending_cmds[$];
   command_type want;

   int  failures      = 0;
   int  items_sent    = 0;
   int  cycle_count   = 0;
   int  kind_seen [5] = '{0, 0, 0, 0, 0};
   int  sum_errors    = 0;
   int  limit_errors  = 0;
   int  req_idle_pct  = 30;
   int  rsp_idle_pct  = 30;
   bit  hold_request  = 1'b0;
   int  idle_levels [4] = '{0, 10, 40, 70};

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   function void emit_command(input logic [2:0] kind, input logic [15:0] addr,
                              input logic [15:0] last, input logic [7:0] data,
                              input logic cause, input logic limit);
      command_type cmd;
      cmd.kind                = kind;
      cmd.address             = addr;
      cmd.end_address         = last;
      cmd.data_byte           = data;
      cmd.error_cause         = cause;
      cmd.error_limit_reached = limit;
      pending_cmds.push_back(cmd);
   endfunction

   function void shift_digit(input int d);
      p_acc  = {p_acc[11:0], 4'(d)};
      p_ndig = p_ndig + 3'd1;
   endfunction

   function void store_byte();
      logic [7:0] v;
      v = p_acc[7:0];
      emit_command(KIND_WRITE, p_wptr, 16'h0000, v, 1'b0, 1'b0);
      p_sum[p_sum_pos] = p_sum[p_sum_pos] ^ v;
      p_sum_pos = (CHECKSUM_BYTES > 1) ? ~p_sum_pos : 1'b0;
      p_wptr    = p_wptr + 16'd1;
      p_acc     = 16'h0000;
      p_ndig    = 3'd0;
   endfunction

   function void verify_checksum();
      logic [7:0] rd0;
      logic [7:0] rd1;
      int         sh;
      bit         ok;
      p_mode = MODE_IDLE;
      if (p_ndig <= BYTE_DIGITS) begin
         rd0 = p_acc[7:0];
         rd1 = 8'h00;
      end else begin
         sh  = (int'(p_ndig) - BYTE_DIGITS) * 4;
         rd0 = 8'(p_acc >> sh);
         rd1 = 8'(p_acc & ((16'd1 << sh) - 16'd1));
      end
      ok = (rd0 == p_sum[0]) && (CHECKSUM_BYTES < 2 || rd1 == p_sum[1]);
      p_acc  = 16'h0000;
      p_ndig = 3'd0;
      if (ok) begin
         p_addr = p_wptr;
      end else if (p_err_count >= ERROR_LIMIT) begin
         emit_command(KIND_ERROR, 16'h0000, 16'h0000, 8'h00, CAUSE_CHECKSUM, 1'b1);
      end else begin
         p_err_count = p_err_count + 8'd1;
         emit_command(KIND_ERROR, 16'h0000, 16'h0000, 8'h00, CAUSE_CHECKSUM, 1'b0);
      end
   endfunction

   function void idle_command(input logic [7:0] c, input int d);
      if (d >= 0) begin
         p_mode = MODE_ADDR;
         p_acc  = 16'(d);
         p_ndig = 3'd1;
      end else begin
         case (c)
            CHAR_NEWLINE: begin
               emit_command(KIND_DUMP_LINE, p_addr, p_addr | 16'h0007, 8'h00, 1'b0, 1'b0);
               p_addr = (p_addr | 16'h0007) + 16'd1;
            end
            CHAR_DOT: begin
               p_mode = MODE_RANGE;
               p_acc  = 16'h0000;
               p_ndig = 3'd0;
            end
            CHAR_DASH, CHAR_COLON: begin
               p_mode    = MODE_WRITE;
               p_wptr    = p_addr;
               p_sum[0]  = 8'h00;
               p_sum[1]  = 8'h00;
               p_sum_pos = 1'b0;
               p_acc     = 16'h0000;
               p_ndig    = 3'd0;
            end
            CHAR_UPPER_G, CHAR_LOWER_G: p_mode = MODE_GO;
            CHAR_SPACE: ;
            default: emit_command(KIND_ERROR, 16'h0000, 16'h0000, 8'h00,
                                  CAUSE_BAD_COMMAND, 1'b0);
         endcase
      end
   endfunction

   function void decode_char(input logic [7:0] c);
      int d;
      d = nibble_of(c);
      case (p_mode)
         MODE_ADDR: begin
            if (d >= 0) begin
               shift_digit(d);
               if (p_ndig >= DIGITS_MAX) begin
                  p_addr = p_acc;
                  p_mode = MODE_IDLE;
               end
            end else begin
               p_addr = p_acc;
               p_mode = MODE_IDLE;
               idle_command(c, d);
            end
         end
         MODE_RANGE: begin
            if (d >= 0 && p_ndig < DIGITS_MAX) begin
               shift_digit(d);
            end else begin
               emit_command(KIND_DUMP_RANGE, p_addr, p_acc, 8'h00, 1'b0, 1'b0);
               if (p_acc >= p_addr || p_addr == 16'hFFFF) begin
                  p_addr = p_acc + 16'd1;
               end else begin
                  p_addr = p_addr + 16'd1;
               end
               p_mode = MODE_IDLE;
               p_acc  = 16'h0000;
               p_ndig = 3'd0;
            end
         end
         MODE_WRITE: begin
            if (d >= 0) begin
               shift_digit(d);
               if (p_ndig >= BYTE_DIGITS) store_byte();
            end else begin
               if (p_ndig > 0) store_byte();
               if (c == CHAR_UPPER_X || c == CHAR_LOWER_X) begin
                  p_mode = MODE_CHECK;
                  p_acc  = 16'h0000;
                  p_ndig = 3'd0;
               end else if (c != CHAR_SPACE) begin
                  p_addr = p_wptr;
                  p_mode = MODE_IDLE;
               end
            end
         end
         MODE_CHECK: begin
            if (d >= 0 && p_ndig < DIGITS_MAX) begin
               shift_digit(d);
            end else begin
               verify_checksum();
            end
         end
         MODE_GO: begin
            if (c == CHAR_NEWLINE) begin
               p_mode = MODE_IDLE;
               emit_command(KIND_EXECUTE, p_addr, 16'h0000, 8'h00, 1'b0, 1'b0);
            end
         end
         default: begin
            p_mode = MODE_IDLE;
            idle_command(c, d);
         end
      endcase
   endfunction

   task automatic compare_field(input string field, input int unsigned want_v,
                                input int unsigned got_v);
      if (want_v != got_v) begin
         $display("%0t ns: %s mismatch, expected %h actual %h", $time, field, want_v, got_v);
         failures++;
      end
   endtask

   // predict on each input transaction, check each result transaction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) decode_char(req_char_in);
         if (rsp_valid && rsp_ready) begin
            if (rsp_kind < 5) kind_seen[rsp_kind]++;
            if (rsp_kind == KIND_ERROR && rsp_error_cause == CAUSE_CHECKSUM) sum_errors++;
            if (rsp_error_limit_reached) limit_errors++;
            if (pending_cmds.size() == 0) begin
               $display("%0t ns: unexpected result, expected none actual kind %0d address %h",
                        $time, rsp_kind, rsp_address);
               failures++;
            end else begin
               want = pending_cmds.pop_front();
               compare_field("kind", want.kind, rsp_kind);
               compare_field("address", want.address, rsp_address);
               compare_field("end_address", want.end_address, rsp_end_address);
               compare_field("data_byte", want.data_byte, rsp_data_byte);
               compare_field("error_cause", want.error_cause, rsp_error_cause);
               compare_field("error_limit_reached", want.error_limit_reached,
                             rsp_error_limit_reached);
            end
         end
      end
   end

   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   task automatic send_char(input logic [7:0] c);
      int gap;
      gap = pick_gap(req_idle_pct);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_char_in = c;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_hex(input logic [15:0] v, input int n);
      for (int i = n - 1; i >= 0; i--) send_char(hex_char(v[i*4 +: 4]));
   endtask

   task automatic send_terminator();
      case ($urandom_range(0, 2))
         0: send_char(CHAR_NEWLINE);
         1: send_char(CHAR_SPACE);
         default: send_char(8'($urandom_range(0, 255)));
      endcase
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int gap;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_ready    = 1'b1;
         end else begin
            gap = pick_gap(rsp_idle_pct);
            if (gap > 0) begin
               rsp_ready = 1'b0;
               repeat (gap - 1) @(negedge clock);
            end else begin
               rsp_ready = 1'b1;
            end
         end
      end
   end

   task automatic test_directed_commands();
      string text;
      // dump line at reset, wrap at FFFF, full range, checked write line,
      // stray end of line, execute, checksum mismatch, bad commands
      text = "\nFfFf\n.fFFf\n-1 a0X01a0\n:7gG~\n:X9 ?";
      req_idle_pct = 30;
      rsp_idle_pct = 30;
      for (int i = 0; i < text.len(); i++) send_char(text[i]);
      send_char(8'hFF);
      send_char(8'h00);
   endtask

   task automatic test_checksum_error_limit();
      req_idle_pct = 0;
      rsp_idle_pct = 20;
      hold_request = 1'b1;
      repeat (FLOOD_LINES) begin
         send_char(CHAR_COLON);
         send_char($urandom_range(0, 1) ? CHAR_UPPER_X : CHAR_LOWER_X);
         send_hex(16'($urandom_range(1, 15)), 1);
         send_char(CHAR_SPACE);
      end
   endtask

   task automatic test_random_commands();
      int         start;
      int         pick;
      int         nbytes;
      int         ndig;
      int         r;
      bit         one;
      logic [7:0] b;
      logic [7:0] sum_lo;
      logic [7:0] sum_hi;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 19) == 0) begin
            req_idle_pct = idle_levels[$urandom_range(0, 3)];
            rsp_idle_pct = idle_levels[$urandom_range(0, 3)];
         end
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            send_hex(16'($urandom), $urandom_range(1, 4));
         end else if (pick < 25) begin
            send_char(CHAR_NEWLINE);
         end else if (pick < 37) begin
            send_char(CHAR_DOT);
            send_hex(16'($urandom), $urandom_range(0, 4));
            send_terminator();
         end else if (pick < 75) begin
            send_char($urandom_range(0, 1) ? CHAR_DASH : CHAR_COLON);
            nbytes = $urandom_range(1, 8);
            sum_lo = 8'h00;
            sum_hi = 8'h00;
            for (int i = 0; i < nbytes; i++) begin
               one  = ($urandom_range(0, 2) == 0);
               ndig = one ? 1 : BYTE_DIGITS;
               b    = one ? 8'($urandom_range(0, 15)) : 8'($urandom);
               send_hex(16'(b), ndig);
               if (i % 2 == 0) sum_lo ^= b;
               else sum_hi ^= b;
               if ((one && i != nbytes - 1) || $urandom_range(0, 3) == 0) send_char(CHAR_SPACE);
            end
            r = $urandom_range(0, 9);
            if (r < 6) begin
               send_char($urandom_range(0, 1) ? CHAR_UPPER_X : CHAR_LOWER_X);
               if (r < 4) send_hex({sum_lo, sum_hi}, 4);
               else send_hex(16'($urandom), $urandom_range(0, 4));
               send_terminator();
            end else if (r < 8) begin
               send_char(CHAR_NEWLINE);
            end else begin
               send_char(8'($urandom_range(0, 255)));
            end
         end else if (pick < 82) begin
            send_char($urandom_range(0, 1) ? CHAR_UPPER_G : CHAR_LOWER_G);
            repeat ($urandom_range(0, 3)) send_char(8'($urandom_range(0, 255)));
            send_char(CHAR_NEWLINE);
         end else begin
            send_char(8'($urandom_range(0, 255)));
         end
      end
   endtask

   always @(posedge clock) cycle_count++;

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_commands();
      test_checksum_error_limit();
      test_random_commands();
      req_valid = 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d characters; checked %0d writes, %0d dump lines, %0d ranges, %0d executes",
               items_sent, kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
      $display("checked %0d error reports: %0d checksum mismatches, %0d at the error limit",
               kind_seen[4], sum_errors, limit_errors);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
